[hdl/ss_pkg.sv]
// Shared types and constants for the sorted set engine.
// Used by ss_cell and sorted_set_engine; depends on nothing else.
package ss_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    typedef enum logic [1:0] {
        MODE_MEMBER = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2
    } t_mode;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        t_mode mode;
        t_key  value;
    } t_in_word;

    typedef struct packed {
        logic       success;
        logic       full_reject;
        logic [4:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic ins;
        logic del;
        t_key key;
    } t_cell_ctl;

endpackage

[hdl/ss_cell.sv]
// One slot of the sorted chain: holds a key, compares it with the probe key
// and takes the probe or a neighbor's key on insert or delete. Uses ss_pkg.
module ss_cell (
    input  logic              i_clk,
    input  ss_pkg::t_cell_ctl i_ctl,
    input  logic              i_occ,
    input  logic              i_prev_lt,
    input  ss_pkg::t_key      i_left_value,
    input  ss_pkg::t_key      i_right_value,
    output logic              o_lt,
    output logic              o_eq,
    output ss_pkg::t_key      o_value
);

    ss_pkg::t_key r_value;
    ss_pkg::t_key n_value;

    assign o_lt    = i_occ && (r_value < i_ctl.key);
    assign o_eq    = i_occ && (r_value == i_ctl.key);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !o_lt) begin
            n_value = i_prev_lt ? i_ctl.key : i_left_value;
        end else if (i_ctl.del && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

[hdl/sorted_set_engine.sv]
// Sorted set engine top level: a chain of ss_cell slots plus count and output register.
// An accepted word's result word is registered and appears on the output register in the next cycle.
// Throughput: one word per cycle while o_stall is low; the whole chain compares and shifts together.
// Reset: synchronous active-low reset empties the set and clears the output valid.
// Depends on ss_pkg and ss_cell.
module sorted_set_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ss_pkg::t_in_word  i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output ss_pkg::t_out_word o_word
);

    localparam int N = ss_pkg::CAPACITY;

    logic [ss_pkg::CNT_W-1:0] r_count;
    logic [ss_pkg::CNT_W-1:0] n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    ss_pkg::t_out_word        r_out;
    ss_pkg::t_out_word        n_out;

    logic [N-1:0]       occ;
    logic [N-1:0]       lt;
    logic [N-1:0]       eq;
    logic [N:0]         prev_lt;
    ss_pkg::t_key       value [N];
    ss_pkg::t_key       left_value [N];
    ss_pkg::t_key       right_value [N];
    ss_pkg::t_cell_ctl  ctl;

    logic accept;
    logic present;
    logic full;
    logic do_ins;
    logic do_del;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign present = |eq;
    assign full    = occ[N-1];
    assign do_ins  = accept && (i_word.mode == ss_pkg::MODE_INSERT) && !present && !full;
    assign do_del  = accept && (i_word.mode == ss_pkg::MODE_DELETE) && present;

    assign ctl.ins = do_ins;
    assign ctl.del = do_del;
    assign ctl.key = i_word.value;

    assign prev_lt[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign occ[g]         = ss_pkg::CNT_W'(g) < r_count;
            assign prev_lt[g+1]   = lt[g];
            assign left_value[g]  = (g == 0) ? value[0] : value[(g == 0) ? 0 : g - 1];
            assign right_value[g] = (g == N - 1) ? value[N-1] : value[(g == N - 1) ? g : g + 1];

            ss_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_occ         (occ[g]),
                .i_prev_lt     (prev_lt[g]),
                .i_left_value  (left_value[g]),
                .i_right_value (right_value[g]),
                .o_lt          (lt[g]),
                .o_eq          (eq[g]),
                .o_value       (value[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_del) begin
            n_count = r_count - 1'b1;
        end
        if (accept) begin
            n_out_valid       = 1'b1;
            n_out.entry_count = 5'(n_count);
            n_out.full_reject = 1'b0;
            case (i_word.mode)
                ss_pkg::MODE_MEMBER: begin
                    n_out.success = present;
                end
                ss_pkg::MODE_INSERT: begin
                    n_out.success     = do_ins;
                    n_out.full_reject = !present && full;
                end
                ss_pkg::MODE_DELETE: begin
                    n_out.success = do_del;
                end
                default: begin
                    n_out.success = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

[bench/tb_set_tracker.sv]
`timescale 1ns / 1ps
// Tracker for the sorted set engine bench: mirrors the key set and queues expected result words.
// Depends on ss_pkg for the word types, the mode codes and CAPACITY.
package tb_set_pkg;

    import ss_pkg::*;

    class set_tracker;

        t_key      keys[$];
        t_out_word pending_results[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_word(t_in_word w);
            int        pos;
            bit        present;
            t_out_word r;
            pos = 0;
            while (pos < keys.size() && keys[pos] < w.value) pos++;
            present = (pos < keys.size()) && (keys[pos] == w.value);
            r = '0;
            case (w.mode)
                MODE_MEMBER: r.success = present;
                MODE_INSERT: begin
                    if (!present) begin
                        if (keys.size() >= CAPACITY) begin
                            r.full_reject = 1'b1;
                        end else begin
                            keys.insert(pos, w.value);
                            r.success = 1'b1;
                        end
                    end
                end
                MODE_DELETE: begin
                    if (present) begin
                        keys.delete(pos);
                        r.success = 1'b1;
                    end
                end
                default: ;
            endcase
            r.entry_count = 5'(keys.size());
            pending_results.push_back(r);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.success !== want.success) begin
                $display("%0t: success expected %0b actual %0b",
                         $time, want.success, got.success);
                errors++;
            end
            if (got.full_reject !== want.full_reject) begin
                $display("%0t: full_reject expected %0b actual %0b",
                         $time, want.full_reject, got.full_reject);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction

    endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top of the sorted set engine bench: clock, reset, word driver, receiver stalls and monitor.
// Depends on ss_pkg, tb_set_pkg and the sorted_set_engine RTL.
module tb_top;

    import ss_pkg::*;
    import tb_set_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam t_key       KEY_MIN     = 32'sh8000_0000;
    localparam t_key       KEY_MAX     = 32'sh7FFF_FFFF;
    localparam int         POOL_SIZE   = 20;
    localparam int         PHASE_WORDS = 150;
    localparam int         HOLD_CYCLES = 60;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    set_tracker tracker;
    t_key       key_pool[POOL_SIZE];
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_req;
    int         hold_left;

    sorted_set_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            tracker.check_word(o_word);
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [1:0] m, input t_key k);
        t_in_word w;
        w.mode  = t_mode'(m);
        w.value = k;
        send_word(w);
    endtask

    task automatic run_directed();
        send_op(MODE_MEMBER, 0);
        send_op(MODE_DELETE, 5);
        send_op(MODE_INSERT, KEY_MAX);
        send_op(MODE_INSERT, KEY_MIN);
        send_op(MODE_INSERT, 0);
        send_op(MODE_INSERT, -1);
        send_op(MODE_INSERT, 0);
        send_op(MODE_MEMBER, 1);
        send_op(MODE_UNUSED, 7);
        send_op(MODE_DELETE, KEY_MAX);
        send_op(MODE_DELETE, KEY_MIN);
        for (int i = 0; i < CAPACITY - 2; i++)
            send_op(MODE_INSERT, t_key'(32'h5A5A_0000 ^ (i * 32'h1111_1111)));
        send_op(MODE_INSERT, 12345);
        send_op(MODE_INSERT, 0);
        send_op(MODE_MEMBER, -1);
        send_op(MODE_DELETE, 0);
    endtask

    function automatic t_key pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 35 && tracker.keys.size() > 0)
            return tracker.keys[$urandom_range(tracker.keys.size() - 1)];
        if (r < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 90)
            return t_key'($urandom);
        case ($urandom_range(3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [1:0] pick_mode(input int ins_w);
        int r;
        if ($urandom_range(99) < 3)
            return MODE_UNUSED;
        r = $urandom_range(99);
        if (r < ins_w)
            return MODE_INSERT;
        if (r < 80)
            return MODE_DELETE;
        return MODE_MEMBER;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
        int ins_w;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i % 2 == 0) ? t_key'($urandom_range(40) - 20) : t_key'($urandom);
        for (int n = 0; n < PHASE_WORDS; n++) begin
            ins_w = ((n / 40) % 2 == 0) ? 60 : 20;
            if (long_hold && n == 40)
                hold_req = 1'b1;
            send_op(pick_mode(ins_w), pick_key());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_word         = '0;
        hold_req       = 1'b0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tracker        = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        run_phase(0, 0, 1'b1);
        run_phase(52, 0, 1'b0);
        run_phase(0, 52, 1'b0);
        run_phase(15, 15, 1'b0);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
